FILE: rtl/core/lfr_pkg.sv
package lfr_pkg;

	localparam logic [1:0] REQ_VICTIM = 2'd0;
	localparam logic [1:0] REQ_PIN    = 2'd1;
	localparam logic [1:0] REQ_UNPIN  = 2'd2;

	localparam logic [6:0] CAPACITY_RESET = 7'd64;
	localparam logic       REG_CAPACITY   = 1'b0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_UNLINK,
		S_CHECK,
		S_LINK,
		S_OUT
	} lfr_state_t;

	typedef struct packed {
		logic accept;
		logic decode;
		logic unlink;
		logic link;
		logic retarget;
		logic out_load;
	} lfr_cmd_t;

	typedef struct packed {
		logic go_unlink;
		logic go_link;
		logic trim_more;
	} lfr_status_t;

endpackage

FILE: rtl/core/lru_frame_replacer_top.sv
// LRU frame replacer: an ordered set of evictable frames, newest at the head.
// Requests enter on the in channel (req_type, frame_num) and each produces
// exactly one result on the out channel (victim_found, victim_frame,
// set_count). Both channels transfer when valid and ready are high together.
// One request is handled at a time. A pin of a member or a victim passes
// through the decode, read, unlink, check and output states; an unpin passes
// through decode, link, check and output, plus read, unlink and check for
// every tail frame dropped to honor capacity; a request that changes nothing
// goes from decode straight to output. The next request can be taken once the
// result is loaded and the block is back in idle. The link memories have a
// registered read, so each unlink reads before the neighbors are rewritten.
// The finished result sits in an output register; the next request is taken
// while it waits, but a new result is held back until the receiver takes
// the old one.
// Reset empties the set and sets capacity to 64. Capacity is to be written at
// byte address 0 of the APB port while the block is idle; nothing checks it.
module lru_frame_replacer_top #(
	parameter int NUM_FRAMES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [5:0]  frame_num,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        victim_found,
	output logic [5:0]  victim_frame,
	output logic [6:0]  set_count,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lfr_pkg::*;

	lfr_cmd_t    cmd;
	lfr_status_t status;
	logic [6:0]  capacity_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY) ? {25'd0, capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
			capacity_q <= pwdata[6:0];
		end
	end

	lfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	lfr_datapath #(.NUM_FRAMES(NUM_FRAMES)) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.req_type     (req_type),
		.frame_num    (frame_num),
		.capacity     (capacity_q),
		.victim_found (victim_found),
		.victim_frame (victim_frame),
		.set_count    (set_count)
	);
endmodule

FILE: rtl/core/lfr_ram.sv
module lfr_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/core/lfr_ctrl.sv
module lfr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  lfr_pkg::lfr_status_t status,
	output lfr_pkg::lfr_cmd_t    cmd
);
	import lfr_pkg::*;

	lfr_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				if (status.go_unlink) state_d = S_READ;
				else if (status.go_link) state_d = S_LINK;
				else state_d = S_OUT;
			end
			S_READ:   state_d = S_UNLINK;
			S_UNLINK: state_d = S_CHECK;
			S_LINK:   state_d = S_CHECK;
			S_CHECK:  state_d = status.trim_more ? S_READ : S_OUT;
			S_OUT:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:   cmd.accept = in_valid;
			S_DECODE: cmd.decode = 1'b1;
			S_UNLINK: cmd.unlink = 1'b1;
			S_LINK:   cmd.link = 1'b1;
			S_CHECK:  cmd.retarget = status.trim_more;
			S_OUT:    cmd.out_load = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

FILE: rtl/core/lfr_datapath.sv
module lfr_datapath #(
	parameter int NUM_FRAMES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lfr_pkg::lfr_cmd_t    cmd,
	output lfr_pkg::lfr_status_t status,
	input  logic [1:0]          req_type,
	input  logic [5:0]          frame_num,
	input  logic [6:0]          capacity,
	output logic                victim_found,
	output logic [5:0]          victim_frame,
	output logic [6:0]          set_count
);
	import lfr_pkg::*;

	// Only frame numbers that fit the six-bit request field can ever be members.
	localparam int NF = (NUM_FRAMES < 64) ? NUM_FRAMES : 64;
	localparam int IW = $clog2(NF);

	logic [1:0]    kind_q;
	logic [5:0]    fid_q;
	logic [IW-1:0] target_q, head_q, tail_q;
	logic [6:0]    count_q;
	logic [NF-1:0] flags_q;
	logic          found_q, trim_q;

	logic [IW-1:0] fidx, prev_rd, next_rd;
	logic          in_range, middle;
	logic          next_we, prev_we;
	logic [IW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;

	assign fidx     = IW'(fid_q);
	assign in_range = (32'(fid_q) < NF);

	assign status.go_unlink = ((kind_q == REQ_VICTIM) && (count_q != 7'd0))
		|| ((kind_q == REQ_PIN) && in_range && flags_q[fidx]);
	assign status.go_link   = (kind_q == REQ_UNPIN) && in_range && !flags_q[fidx];
	assign status.trim_more = trim_q && (count_q > capacity);

	// An inner frame is spliced out by joining its two neighbors.
	assign middle = (count_q > 7'd1) && (target_q != tail_q) && (target_q != head_q);

	always_comb begin
		next_we    = 1'b0;
		prev_we    = 1'b0;
		next_waddr = prev_rd;
		next_wdata = next_rd;
		prev_waddr = next_rd;
		prev_wdata = prev_rd;
		if (cmd.unlink && middle) begin
			next_we = 1'b1;
			prev_we = 1'b1;
		end else if (cmd.link && (count_q != 7'd0)) begin
			next_we    = 1'b1;
			prev_we    = 1'b1;
			next_waddr = fidx;
			next_wdata = head_q;
			prev_waddr = head_q;
			prev_wdata = fidx;
		end
	end

	lfr_ram #(.WIDTH(IW), .DEPTH(NF)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.raddr (target_q),
		.rdata (next_rd)
	);

	lfr_ram #(.WIDTH(IW), .DEPTH(NF)) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_waddr),
		.wdata (prev_wdata),
		.raddr (target_q),
		.rdata (prev_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= req_type;
			fid_q  <= frame_num;
		end
		if (cmd.decode) begin
			target_q <= (kind_q == REQ_VICTIM) ? tail_q : fidx;
			found_q  <= (kind_q == REQ_VICTIM) && (count_q != 7'd0);
		end else if (cmd.retarget) begin
			target_q <= tail_q;
		end
		if (cmd.out_load) begin
			victim_found <= found_q;
			victim_frame <= found_q ? 6'(target_q) : 6'd0;
			set_count    <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= 7'd0;
			flags_q <= '0;
			trim_q  <= 1'b0;
		end else begin
			if (cmd.decode) trim_q <= 1'b0;
			if (cmd.unlink) begin
				if (count_q <= 7'd1) begin
					head_q <= '0;
					tail_q <= '0;
				end else if (target_q == tail_q) begin
					tail_q <= prev_rd;
				end else if (target_q == head_q) begin
					head_q <= next_rd;
				end
				flags_q[target_q] <= 1'b0;
				if (count_q != 7'd0) count_q <= count_q - 7'd1;
			end
			if (cmd.link) begin
				if (count_q == 7'd0) tail_q <= fidx;
				head_q        <= fidx;
				flags_q[fidx] <= 1'b1;
				count_q       <= count_q + 7'd1;
				trim_q        <= 1'b1;
			end
		end
	end
endmodule
